/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the broadcast ring.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/brvs_pkg.sv */
// Shared types and fixed widths for the broadcast ring with versioned slots.
// No dependencies; used by the channel interfaces and the top level.
package brvs_pkg;

  localparam int unsigned DATA_W  = 64;  // slot data word
  localparam int unsigned COUNT_W = 32;  // per-slot write count
  localparam int unsigned RID_W   = 2;   // reader id field

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

endpackage

/* hw/rtl/brvs_item_if.sv */
// Request channel of the broadcast ring: one push or pop per beat.
// Depends on brvs_pkg for the opcode type and field widths.
interface brvs_item_if import brvs_pkg::*; ();

  logic              valid;
  logic              ready;
  op_e               operation;
  logic [RID_W-1:0]  reader_id;
  logic [DATA_W-1:0] push_value;

  modport source (output valid, operation, reader_id, push_value, input ready);
  modport sink   (input valid, operation, reader_id, push_value, output ready);

endinterface

/* hw/rtl/brvs_result_if.sv */
// Result channel of the broadcast ring: one result beat per request.
// Depends on brvs_pkg for field widths.
interface brvs_result_if import brvs_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              pop_valid;
  logic [DATA_W-1:0] pop_value;

  modport source (output valid, pop_valid, pop_value, input ready);
  modport sink   (input valid, pop_valid, pop_value, output ready);

endinterface

/* hw/rtl/broadcast_ring_versioned_slots.sv */
// Broadcast ring, one writer and READER_COUNT readers, versioned slots.
// Request beats arrive on in_i (valid/ready): a push stores push_value at
// the writer position and never blocks; a pop for reader_id returns the
// slot at that reader's position if the slot was written more often than
// the reader's lap count, else it reports empty (pop_valid low, value 0).
// Every request gives exactly one result beat on out_o, in order; a push
// always answers with pop_valid low.
// An accepted request passes the second stage, then the result register.
// Throughput: one request per cycle while out_o does not stall; the slot
// memories are read once per cycle by the request being accepted and
// written once by the request in the second stage, with a forwarding
// register covering same-slot hazards. When out_o stalls, the result
// register holds and in_i drops ready once stage two is also occupied.
// Reset clears writer and reader positions, laps and a wrap flag at once.
// Slot counts need no clearing pass: a slot never written reads as count
// zero, decided from the writer position and the wrap flag.
// Depends on brvs_pkg, brvs_item_if, brvs_result_if and assert_macros.svh.
`include "assert_macros.svh"

module broadcast_ring_versioned_slots import brvs_pkg::*; #(
  parameter int unsigned RING_DEPTH   = 64,
  parameter int unsigned READER_COUNT = 4,
  parameter int unsigned LAP_BITS     = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  brvs_item_if.sink    in_i,
  brvs_result_if.source out_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned RIX_W = (READER_COUNT > 1) ? $clog2(READER_COUNT) : 1;
  localparam int unsigned CMP_W = (LAP_BITS > COUNT_W) ? LAP_BITS : COUNT_W;
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);

  // Slot memories (no reset; unwritten entries are masked by the fill logic)
  logic [DATA_W-1:0]   slot_data_q [RING_DEPTH];
  logic [COUNT_W-1:0]  slot_cnt_q  [RING_DEPTH];

  // Architectural state
  logic [PTR_W-1:0]    wr_pos_q;
  logic                wrapped_q;
  logic [PTR_W-1:0]    rd_pos_q [READER_COUNT];
  logic [LAP_BITS-1:0] lap_q    [READER_COUNT];

  // Second stage
  logic                b_valid_q;
  op_e                 b_op_q;
  logic                b_rid_ok_q;
  logic [RIX_W-1:0]    b_idx_q;
  logic [PTR_W-1:0]    b_addr_q;
  logic [LAP_BITS-1:0] b_lap_q;
  logic [DATA_W-1:0]   b_val_q;
  logic [DATA_W-1:0]   data_rd_q;
  logic [COUNT_W-1:0]  cnt_rd_q;
  logic                fwd_hit_q;
  logic [DATA_W-1:0]   fwd_data_q;
  logic [COUNT_W-1:0]  fwd_cnt_q;

  // Result register
  logic                out_valid_q;
  logic                out_pop_valid_q;
  logic [DATA_W-1:0]   out_pop_value_q;

  logic                b_adv;
  logic                a_ok;
  logic                in_beat;
  logic                rid_ok_a;
  logic [RIX_W-1:0]    idx_a;
  logic [PTR_W-1:0]    pos_a;
  logic [LAP_BITS-1:0] lap_a;
  logic [PTR_W-1:0]    wp_a;
  logic [PTR_W-1:0]    addr_a;
  logic                fwd_hit_d;
  logic                b_push;
  logic                b_commit_pop;
  logic [DATA_W-1:0]   data_b;
  logic                written_b;
  logic [COUNT_W-1:0]  cnt_b;
  logic [COUNT_W-1:0]  cnt_new;
  logic [PTR_W-1:0]    addr_nxt;
  logic                hit_b;
  logic [LAP_BITS-1:0] lap_new;

  // Flow control: stage two moves when the result register is free
  assign b_adv   = b_valid_q && (!out_valid_q || out_o.ready);
  assign a_ok    = !b_valid_q || b_adv;
  assign in_beat = in_i.valid && a_ok;
  assign in_i.ready = a_ok;

  // Second stage: resolve slot contents and the outcome
  assign b_push    = (b_op_q == OP_PUSH);
  assign data_b    = fwd_hit_q ? fwd_data_q : data_rd_q;
  assign written_b = fwd_hit_q || wrapped_q || (b_addr_q < wr_pos_q);
  assign cnt_b     = written_b ? (fwd_hit_q ? fwd_cnt_q : cnt_rd_q) : '0;
  assign cnt_new   = (&cnt_b) ? cnt_b : cnt_b + COUNT_W'(1);
  assign addr_nxt  = (b_addr_q == LAST_POS) ? '0 : b_addr_q + PTR_W'(1);
  assign hit_b     = !b_push && b_rid_ok_q && (CMP_W'(cnt_b) > CMP_W'(b_lap_q));
  assign lap_new   = ((addr_nxt == '0) && !(&b_lap_q)) ? b_lap_q + LAP_BITS'(1) : b_lap_q;
  assign b_commit_pop = b_adv && hit_b;

  // First stage: slot address from state as it stands after stage two
  assign rid_ok_a = (32'(in_i.reader_id) < 32'(READER_COUNT));
  assign idx_a    = RIX_W'(in_i.reader_id);

  always_comb begin
    pos_a = '0;
    lap_a = '0;
    if (rid_ok_a) begin
      if (b_commit_pop && (b_idx_q == idx_a)) begin
        pos_a = addr_nxt;
        lap_a = lap_new;
      end else begin
        pos_a = rd_pos_q[idx_a];
        lap_a = lap_q[idx_a];
      end
    end
  end

  assign wp_a      = (b_adv && b_push) ? addr_nxt : wr_pos_q;
  assign addr_a    = (in_i.operation == OP_PUSH) ? wp_a : pos_a;
  assign fwd_hit_d = in_beat && b_adv && b_push && (b_addr_q == addr_a);

  // Slot memories: one write from stage two, one registered read
  always_ff @(posedge clk_i) begin
    if (b_adv && b_push) begin
      slot_data_q[b_addr_q] <= b_val_q;
      slot_cnt_q[b_addr_q]  <= cnt_new;
    end
    if (a_ok) begin
      data_rd_q <= slot_data_q[addr_a];
      cnt_rd_q  <= slot_cnt_q[addr_a];
    end
  end

  // Stage two payload and forwarding data
  always_ff @(posedge clk_i) begin
    if (a_ok) begin
      b_op_q     <= in_i.operation;
      b_rid_ok_q <= rid_ok_a;
      b_idx_q    <= idx_a;
      b_addr_q   <= addr_a;
      b_lap_q    <= lap_a;
      b_val_q    <= in_i.push_value;
      fwd_data_q <= b_val_q;
      fwd_cnt_q  <= cnt_new;
    end
  end

  // Stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else if (a_ok) begin
      b_valid_q <= in_i.valid;
      fwd_hit_q <= fwd_hit_d;
    end
  end

  // Writer position and wrap flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q  <= '0;
      wrapped_q <= 1'b0;
    end else if (b_adv && b_push) begin
      wr_pos_q <= addr_nxt;
      if (addr_nxt == '0) begin
        wrapped_q <= 1'b1;
      end
    end
  end

  // Reader positions and laps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < READER_COUNT; i++) begin
        rd_pos_q[i] <= '0;
        lap_q[i]    <= '0;
      end
    end else if (b_commit_pop) begin
      rd_pos_q[b_idx_q] <= addr_nxt;
      lap_q[b_idx_q]    <= lap_new;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_pop_valid_q <= hit_b;
      out_pop_value_q <= hit_b ? data_b : '0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pop_valid = out_pop_valid_q;
  assign out_o.pop_value = out_pop_value_q;

  // Checks
  `ASSERT_IMPL(a_empty_is_zero, clk_i, rst_ni,
               out_valid_q && !out_pop_valid_q, out_pop_value_q == '0)
  `ASSERT_NEXT(a_push_never_hits, clk_i, rst_ni,
               b_adv && (b_push || !b_rid_ok_q), !out_pop_valid_q)
  `ASSERT_IMPL(a_fwd_has_item, clk_i, rst_ni, fwd_hit_q, b_valid_q)
  `ASSERT_NEXT(a_wrap_sticky, clk_i, rst_ni, wrapped_q, wrapped_q)

endmodule
